// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the run-length encoder RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`endif

// File: hdl/slrle_pkg.sv
// ----------------------------------------------------------------------------
// slrle_pkg
// Types and constants of the strided line run-length encoder.
// ----------------------------------------------------------------------------
package slrle_pkg;

	localparam int unsigned FIELD_W   = 16;
	localparam int unsigned CFG_IDX_W = 1;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_LINE_TOTAL  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 1'b1;

	typedef logic [FIELD_W-1:0] word_t;

	// one closed run as it leaves the block
	typedef struct packed {
		word_t run_value;
		word_t run_length;
		word_t run_start;
		logic  final_of_burst;
	} run_t;

endpackage

// File: hdl/slrle_sample_if.sv
// ----------------------------------------------------------------------------
// slrle_sample_if
// Valid/ready channel carrying one sample per request.
// ----------------------------------------------------------------------------
interface slrle_sample_if;
	logic                valid;
	logic                ready;
	slrle_pkg::word_t    sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

// File: hdl/slrle_run_if.sv
// ----------------------------------------------------------------------------
// slrle_run_if
// Valid/ready channel carrying one closed run per request.
// ----------------------------------------------------------------------------
interface slrle_run_if;
	logic                valid;
	logic                ready;
	slrle_pkg::word_t    run_value;
	slrle_pkg::word_t    run_length;
	slrle_pkg::word_t    run_start;
	logic                final_of_burst;

	modport source (output valid, output run_value, output run_length,
		output run_start, output final_of_burst, input ready);
	modport sink   (input valid, input run_value, input run_length,
		input run_start, input final_of_burst, output ready);
endinterface

// File: hdl/strided_line_run_length_encoder.sv
// ----------------------------------------------------------------------------
// strided_line_run_length_encoder
// Run-length encoder over lines of samples with strided linear positions.
// ----------------------------------------------------------------------------
// A new sample request is taken in every cycle while the four-entry result
// queue has room for two runs, so the sustained rate is one sample per cycle
// as long as the run side drains at least one run per cycle on average. Each
// sample closes zero, one or two runs; a sample closing two runs fills two
// queue slots at once, and the run side drains at most one run per cycle, so a burst
// of such samples slows the sample side to the drain rate of the queue's
// single read port. The run state (held value, count, start, line and row
// counters, strided position) updates in the cycle the sample is taken, and
// its closed runs appear on the run channel from the following cycle at the earliest.
// No clearing pass is needed after reset. Write line_total and line_length
// only while the block is idle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strided_line_run_length_encoder #(
	parameter int unsigned SAMPLE_BITS = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [slrle_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  slrle_pkg::word_t                     cfg_data,
	slrle_sample_if.sink                         samples,
	slrle_run_if.source                          runs
);

	// Only the low bits of a sample that fit both the port and SAMPLE_BITS count.
	localparam int unsigned HB = (SAMPLE_BITS < slrle_pkg::FIELD_W) ?
		SAMPLE_BITS : slrle_pkg::FIELD_W;
	localparam int unsigned DEPTH = 4;
	localparam int unsigned PTR_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned FW    = slrle_pkg::FIELD_W;

	// configuration
	slrle_pkg::word_t line_total_q;
	slrle_pkg::word_t line_length_q;

	// open run and position state
	logic [HB-1:0]    held_q;
	slrle_pkg::word_t count_q;
	slrle_pkg::word_t start_q;
	slrle_pkg::word_t line_q;
	slrle_pkg::word_t row_q;
	slrle_pkg::word_t pos_q;

	// result queue
	slrle_pkg::run_t  queue_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;

	logic             accept;
	logic             pop;
	logic [HB-1:0]    s;
	logic             row0;
	logic             change;
	logic             line_end;
	logic             frame_end;
	slrle_pkg::word_t pos_new;
	logic [HB-1:0]    held_new;
	slrle_pkg::word_t count_new;
	slrle_pkg::word_t start_new;
	slrle_pkg::word_t row_new;
	slrle_pkg::word_t line_new;
	slrle_pkg::run_t  res_a;
	slrle_pkg::run_t  res_b;
	logic             push_a;
	logic             push_b;
	logic [CNT_W-1:0] n_push;
	slrle_pkg::run_t  head;

	// Take a sample only when two free slots are guaranteed.
	assign samples.ready = (cnt_q <= CNT_W'(DEPTH - 2));
	assign accept        = samples.valid && samples.ready;
	assign pop           = runs.valid && runs.ready;

	always_comb begin
		s      = samples.sample[HB-1:0];
		row0   = (row_q == '0);
		// First sample of a line sits at the line number; later ones step by the stride.
		pos_new = row0 ? line_q : pos_q + line_total_q;
		change  = !row0 && (s != held_q);

		// The run closed by a value change reports the old state.
		res_a.run_value      = FW'(held_q);
		res_a.run_length     = count_q;
		res_a.run_start      = start_q;

		if (row0 || change) begin
			held_new  = s;
			start_new = pos_new + FW'(1);
			count_new = FW'(1);
		end else begin
			held_new  = held_q;
			start_new = start_q;
			count_new = count_q + FW'(1);
		end

		// Compare one bit wider so a full-scale count does not wrap.
		line_end  = ({1'b0, row_q} + 17'd1) >= {1'b0, line_length_q};
		frame_end = ({1'b0, line_q} + 17'd1) >= {1'b0, line_total_q};

		// Line end closes whatever run is open after this sample.
		res_b.run_value      = FW'(held_new);
		res_b.run_length     = count_new;
		res_b.run_start      = start_new;
		res_b.final_of_burst = 1'b1;
		res_a.final_of_burst = !line_end;

		if (line_end) begin
			row_new  = '0;
			line_new = frame_end ? '0 : line_q + FW'(1);
		end else begin
			row_new  = row_q + FW'(1);
			line_new = line_q;
		end

		push_a = accept && change;
		push_b = accept && line_end;
		n_push = CNT_W'(push_a) + CNT_W'(push_b);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_total_q  <= FW'(1);
			line_length_q <= FW'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				slrle_pkg::REG_LINE_TOTAL:  line_total_q  <= cfg_data;
				slrle_pkg::REG_LINE_LENGTH: line_length_q <= cfg_data;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q  <= '0;
			count_q <= '0;
			start_q <= '0;
			line_q  <= '0;
			row_q   <= '0;
			pos_q   <= '0;
		end else if (accept) begin
			held_q  <= held_new;
			count_q <= count_new;
			start_q <= start_new;
			line_q  <= line_new;
			row_q   <= row_new;
			pos_q   <= pos_new;
		end
	end

	// Push the change run first, then the line-end run behind it.
	always_ff @(posedge clk) begin
		if (push_a) begin
			queue_q[wr_ptr_q] <= res_a;
		end else if (push_b) begin
			queue_q[wr_ptr_q] <= res_b;
		end
		if (push_a && push_b) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= res_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(n_push);
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			cnt_q <= cnt_q + n_push - CNT_W'(pop);
		end
	end

	assign head                = queue_q[rd_ptr_q];
	assign runs.valid          = (cnt_q != '0);
	assign runs.run_value      = head.run_value;
	assign runs.run_length     = head.run_length;
	assign runs.run_start      = head.run_start;
	assign runs.final_of_burst = head.final_of_burst;

	// Queue never overflows.
	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, cnt_q <= CNT_W'(DEPTH))
	// A sample is only taken with room for a full burst.
	`ASSERT_IMPL(a_room_on_accept, clk, arst_n, accept, cnt_q <= CNT_W'(DEPTH - 2))
	// A non-final run always has its partner already queued behind it.
	`ASSERT_IMPL(a_partner_queued, clk, arst_n, runs.valid && !runs.final_of_burst,
		cnt_q >= CNT_W'(2))
	// A line-end sample restarts the row counter.
	`ASSERT_NEXT(a_row_restart, clk, arst_n, accept && line_end && !cfg_we, row_q == '0)

endmodule
